// File: hdl/lmcfb_pkg.sv
`timescale 1ns / 1ps

package lmcfb_pkg;

    localparam int MAX_DEVICES = 8;

    localparam logic [3:0] DEV_COUNT_RESET = 4'd8;

    // Command codes
    localparam logic [3:0] OP_SET_LED    = 4'd0;
    localparam logic [3:0] OP_SET_ROW    = 4'd1;
    localparam logic [3:0] OP_SET_COL    = 4'd2;
    localparam logic [3:0] OP_CLEAR_DEV  = 4'd3;
    localparam logic [3:0] OP_PUSH_ROW   = 4'd4;
    localparam logic [3:0] OP_PUSH_RALL  = 4'd5;
    localparam logic [3:0] OP_POWER_DOWN = 4'd6;
    localparam logic [3:0] OP_BRIGHTNESS = 4'd7;
    localparam logic [3:0] OP_SCAN_LIMIT = 4'd8;
    localparam logic [3:0] OP_RAW_WRITE  = 4'd9;
    localparam logic [3:0] OP_PUSH_ALL   = 4'd10;

    // Chip register addresses
    localparam logic [3:0] REG_NOOP      = 4'd0;
    localparam logic [3:0] REG_INTENSITY = 4'd10;
    localparam logic [3:0] REG_SCANLIMIT = 4'd11;
    localparam logic [3:0] REG_SHUTDOWN  = 4'd12;

    localparam logic [7:0] INTENSITY_LIMIT = 8'd16;
    localparam logic [7:0] SCAN_LIMIT_MAX  = 8'd8;

    typedef struct packed {
        logic [3:0] command;
        logic [2:0] device;
        logic [2:0] row;
        logic [2:0] column;
        logic       bit_value;
        logic       send;
        logic [7:0] value;
        logic [3:0] reg_select;
    } t_in_item;

    typedef struct packed {
        logic [2:0] chain_position;
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       end_of_frame;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PREP_RD,
        S_PREP_WR,
        S_WORD_RD,
        S_WORD_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic prep_rd;
        logic prep_wr;
        logic word_rd;
        logic word_out;
        logic next_row;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic act;
        logic emit;
        logic multi_row;
        logic row_all;
        logic pos_zero;
        logic row_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hdl/lmcfb_ram.sv
`timescale 1ns / 1ps

module lmcfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lmcfb_ctrl.sv
`timescale 1ns / 1ps

module lmcfb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lmcfb_pkg::t_dp_sts i_sts,
    output lmcfb_pkg::t_dp_cmd o_cmd
);

    lmcfb_pkg::t_state r_state;
    lmcfb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmcfb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            lmcfb_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lmcfb_pkg::S_DECODE;
                end
            end
            lmcfb_pkg::S_DECODE: begin
                if (!i_sts.act) begin
                    n_state = lmcfb_pkg::S_IDLE;
                end else if (i_sts.row_all) begin
                    n_state = lmcfb_pkg::S_WORD_RD;
                end else begin
                    n_state = lmcfb_pkg::S_PREP_RD;
                end
            end
            lmcfb_pkg::S_PREP_RD: begin
                o_cmd.prep_rd = 1'b1;
                n_state       = lmcfb_pkg::S_PREP_WR;
            end
            lmcfb_pkg::S_PREP_WR: begin
                o_cmd.prep_wr = 1'b1;
                if (i_sts.emit) begin
                    n_state = lmcfb_pkg::S_WORD_RD;
                end else if (i_sts.multi_row && !i_sts.row_last) begin
                    o_cmd.next_row = 1'b1;
                    n_state        = lmcfb_pkg::S_PREP_RD;
                end else begin
                    n_state = lmcfb_pkg::S_IDLE;
                end
            end
            lmcfb_pkg::S_WORD_RD: begin
                o_cmd.word_rd = 1'b1;
                n_state       = lmcfb_pkg::S_WORD_OUT;
            end
            lmcfb_pkg::S_WORD_OUT: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.word_out = 1'b1;
                    if (!i_sts.pos_zero) begin
                        n_state = lmcfb_pkg::S_WORD_RD;
                    end else if (i_sts.multi_row && !i_sts.row_last) begin
                        o_cmd.next_row = 1'b1;
                        n_state = i_sts.row_all ? lmcfb_pkg::S_WORD_RD
                                                : lmcfb_pkg::S_PREP_RD;
                    end else begin
                        n_state = lmcfb_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lmcfb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/lmcfb_dp.sv
`timescale 1ns / 1ps

module lmcfb_dp #(
    parameter int MAX_DEVICES = lmcfb_pkg::MAX_DEVICES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_data,
    input  lmcfb_pkg::t_in_item  i_in_item,
    input  lmcfb_pkg::t_dp_cmd   i_cmd,
    output lmcfb_pkg::t_dp_sts   o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lmcfb_pkg::t_out_item o_out_item
);

    localparam int         DEPTH   = 8 * MAX_DEVICES;
    localparam int         AW      = $clog2(DEPTH);
    localparam logic [3:0] MAX_LEN = 4'(MAX_DEVICES);

    function automatic logic f_multi_row(input logic [3:0] cmd);
        return (cmd == lmcfb_pkg::OP_SET_COL) || (cmd == lmcfb_pkg::OP_CLEAR_DEV) ||
               (cmd == lmcfb_pkg::OP_PUSH_ALL);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [2:0] row, input logic [2:0] chip);
        return AW'(int'(row) * MAX_DEVICES + int'(chip));
    endfunction

    logic [3:0]           r_dev_count;
    lmcfb_pkg::t_in_item  r_item;
    logic [2:0]           r_row;
    logic [2:0]           r_pos;
    logic [3:0]           r_word_addr;
    logic [7:0]           r_word_data;
    logic [DEPTH-1:0]     r_valid;
    logic                 r_rd_valid;
    logic                 r_out_valid;
    lmcfb_pkg::t_out_item r_out_item;

    logic [3:0]           w_len;
    logic [2:0]           w_pos_init;
    logic                 w_dev_ok;
    logic                 w_act;
    logic                 w_emit;
    logic                 w_writes;
    logic                 w_row_all;
    logic                 w_out_free;
    logic                 w_ram_re;
    logic [AW-1:0]        w_raddr;
    logic [AW-1:0]        w_waddr;
    logic [7:0]           w_ram_q;
    logic [7:0]           w_old;
    logic [7:0]           w_mask;
    logic                 w_bit;
    logic [7:0]           w_new;
    logic [3:0]           w_row_reg;
    logic [3:0]           n_word_addr;
    logic [7:0]           n_word_data;
    lmcfb_pkg::t_out_item w_word;

    // Chain length: out-of-range counts act as the full chain
    assign w_len = (r_dev_count == 4'd0 || r_dev_count > MAX_LEN) ? MAX_LEN : r_dev_count;
    assign w_pos_init = 3'(w_len - 4'd1);
    assign w_dev_ok   = {1'b0, r_item.device} < w_len;
    assign w_row_reg  = {1'b0, r_row} + 4'd1;

    always_comb begin
        w_act     = 1'b0;
        w_emit    = 1'b0;
        w_writes  = 1'b0;
        w_row_all = 1'b0;
        unique case (r_item.command) inside
            lmcfb_pkg::OP_SET_LED, lmcfb_pkg::OP_SET_ROW, lmcfb_pkg::OP_SET_COL: begin
                w_act    = w_dev_ok;
                w_emit   = r_item.send;
                w_writes = 1'b1;
            end
            lmcfb_pkg::OP_CLEAR_DEV: begin
                w_act    = w_dev_ok;
                w_emit   = 1'b1;
                w_writes = 1'b1;
            end
            lmcfb_pkg::OP_PUSH_ROW, lmcfb_pkg::OP_POWER_DOWN, lmcfb_pkg::OP_RAW_WRITE: begin
                w_act  = w_dev_ok;
                w_emit = 1'b1;
            end
            lmcfb_pkg::OP_BRIGHTNESS: begin
                w_act  = w_dev_ok && (r_item.value < lmcfb_pkg::INTENSITY_LIMIT);
                w_emit = 1'b1;
            end
            lmcfb_pkg::OP_SCAN_LIMIT: begin
                w_act  = w_dev_ok && (r_item.value < lmcfb_pkg::SCAN_LIMIT_MAX);
                w_emit = 1'b1;
            end
            lmcfb_pkg::OP_PUSH_RALL, lmcfb_pkg::OP_PUSH_ALL: begin
                w_act     = 1'b1;
                w_emit    = 1'b1;
                w_row_all = 1'b1;
            end
            default: begin
                w_act = 1'b0;
            end
        endcase
    end

    // Frame store: never-written entries read as zero through the valid bits
    assign w_ram_re = i_cmd.prep_rd || i_cmd.word_rd;
    assign w_raddr  = i_cmd.word_rd ? f_addr(r_row, r_pos) : f_addr(r_row, r_item.device);
    assign w_waddr  = f_addr(r_row, r_item.device);

    lmcfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.prep_wr && w_writes),
        .i_waddr (w_waddr),
        .i_wdata (w_new),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    assign w_old  = r_rd_valid ? w_ram_q : 8'h00;
    assign w_mask = 8'h80 >> r_item.column;
    assign w_bit  = (r_item.command == lmcfb_pkg::OP_SET_COL) ?
                    r_item.value[3'd7 - r_row] : r_item.bit_value;

    always_comb begin
        w_new = w_old;
        case (r_item.command) inside
            lmcfb_pkg::OP_SET_LED,
            lmcfb_pkg::OP_SET_COL:   w_new = w_bit ? (w_old | w_mask) : (w_old & ~w_mask);
            lmcfb_pkg::OP_SET_ROW:   w_new = r_item.value;
            lmcfb_pkg::OP_CLEAR_DEV: w_new = 8'h00;
            default:                 w_new = w_old;
        endcase
    end

    always_comb begin
        n_word_addr = lmcfb_pkg::REG_NOOP;
        n_word_data = 8'h00;
        unique case (r_item.command) inside
            lmcfb_pkg::OP_SET_LED, lmcfb_pkg::OP_SET_ROW, lmcfb_pkg::OP_SET_COL,
            lmcfb_pkg::OP_CLEAR_DEV, lmcfb_pkg::OP_PUSH_ROW: begin
                n_word_addr = w_row_reg;
                n_word_data = w_new;
            end
            lmcfb_pkg::OP_POWER_DOWN: begin
                n_word_addr = lmcfb_pkg::REG_SHUTDOWN;
                n_word_data = {7'd0, ~r_item.bit_value};
            end
            lmcfb_pkg::OP_BRIGHTNESS: begin
                n_word_addr = lmcfb_pkg::REG_INTENSITY;
                n_word_data = r_item.value;
            end
            lmcfb_pkg::OP_SCAN_LIMIT: begin
                n_word_addr = lmcfb_pkg::REG_SCANLIMIT;
                n_word_data = r_item.value;
            end
            lmcfb_pkg::OP_RAW_WRITE: begin
                n_word_addr = r_item.reg_select;
                n_word_data = r_item.value;
            end
            default: begin
                n_word_addr = lmcfb_pkg::REG_NOOP;
            end
        endcase
    end

    // Word for the current chain position
    always_comb begin
        w_word.chain_position = r_pos;
        w_word.end_of_frame   = (r_pos == 3'd0);
        w_word.last           = (r_pos == 3'd0) &&
                                !(f_multi_row(r_item.command) && r_row != 3'd7);
        if (w_row_all) begin
            w_word.reg_address = w_row_reg;
            w_word.reg_data    = w_old;
        end else if (r_pos == r_item.device) begin
            w_word.reg_address = r_word_addr;
            w_word.reg_data    = r_word_data;
        end else begin
            w_word.reg_address = lmcfb_pkg::REG_NOOP;
            w_word.reg_data    = 8'h00;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_count <= lmcfb_pkg::DEV_COUNT_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_count <= i_cfg_data;
            end
            if (i_cmd.prep_wr && w_writes) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cmd.word_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
            r_row  <= f_multi_row(i_in_item.command) ? 3'd0 : i_in_item.row;
            r_pos  <= w_pos_init;
        end else if (i_cmd.next_row) begin
            r_row <= r_row + 3'd1;
            r_pos <= w_pos_init;
        end else if (i_cmd.word_out) begin
            r_pos <= r_pos - 3'd1;
        end
        if (w_ram_re) begin
            r_rd_valid <= r_valid[w_raddr];
        end
        if (i_cmd.prep_wr) begin
            r_word_addr <= n_word_addr;
            r_word_data <= n_word_data;
        end
        if (i_cmd.word_out) begin
            r_out_item <= w_word;
        end
    end

    assign o_sts.act       = w_act;
    assign o_sts.emit      = w_emit;
    assign o_sts.multi_row = f_multi_row(r_item.command);
    assign o_sts.row_all   = w_row_all;
    assign o_sts.pos_zero  = (r_pos == 3'd0);
    assign o_sts.row_last  = (r_row == 3'd7);
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: hdl/led_matrix_chain_frame_builder.sv
`timescale 1ns / 1ps
// Sequence: a command is accepted and decoded; then, for per-chip commands, the frame store
// entry is read and, for LED updates, written back once per frame (read-modify-write). Each
// chain word then takes a frame store read and an output load, and waits while the output
// stalls. The push-row-to-all and push-all commands skip the read-modify-write. A dropped
// item ends after decode; no new command is accepted until the current one is finished.
// Reset (synchronous, active low): chip count 8, frame store reads as zero at once.

module led_matrix_chain_frame_builder #(
    parameter int MAX_DEVICES = lmcfb_pkg::MAX_DEVICES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lmcfb_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lmcfb_pkg::t_out_item o_out_item
);

    lmcfb_pkg::t_dp_cmd w_cmd;
    lmcfb_pkg::t_dp_sts w_sts;

    // Sequencer: decode, per-frame buffer update for per-chip commands, then one word per chain position
    lmcfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Frame store, chip count register, word builder and output register
    lmcfb_dp #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // the last word of a command always closes a frame
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> o_out_item.end_of_frame)
        else $error("last word without end of frame");

    // only position zero closes a frame
    a_eof_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.end_of_frame |-> o_out_item.chain_position == 3'd0)
        else $error("end of frame away from position zero");

    // the input is stalled in the cycle after an item is accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted back to back");

    // a word is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.word_out |-> !o_out_valid || !i_out_stall)
        else $error("pending word overwritten");
`endif

endmodule
